// File: design/gas_valve_duty_sequencer_unit_assert.svh
// ----------------------------------------------------------------------------
// Gas valve duty sequencer assertion macros
// Shared concurrent assertion forms for the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef GAS_VALVE_DUTY_SEQUENCER_UNIT_ASSERT_SVH
`define GAS_VALVE_DUTY_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define GVDS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define GVDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/gvds_pkg.sv
// ----------------------------------------------------------------------------
// Gas valve duty sequencer package
// Constants, register indexes and the percentage table lookups.
// ----------------------------------------------------------------------------
`default_nettype none

package gvds_pkg;

  localparam int NUM_VALVES_DEF = 3;
  localparam int NUM_LEVELS_DEF = 28;

  localparam int ROM_LEVELS = 28;
  localparam int ROM_VALVES = 3;

  localparam logic [9:0]  FULL_PERCENT = 10'd100;
  localparam logic [15:0] CYCLE_RESET  = 16'd10000;

  // floor(x/100) = (x * ceil(2^30/100)) >> 30, exact for x below 2^23
  localparam int          RECIP_SHIFT = 30;
  localparam logic [23:0] RECIP_100   = 24'((2 ** RECIP_SHIFT + 99) / 100);

  // Register indexes on the configuration port
  localparam logic REG_CYCLE_LENGTH = 1'b0;
  localparam logic REG_AUTO_ADVANCE = 1'b1;

  typedef logic [6:0] pct_t;

  localparam pct_t PERCENT_ROM [ROM_LEVELS][ROM_VALVES] = '{
    '{7'd100, 7'd0,   7'd0  }, '{7'd83,  7'd17,  7'd0  },
    '{7'd67,  7'd33,  7'd0  }, '{7'd83,  7'd0,   7'd17 },
    '{7'd50,  7'd50,  7'd0  }, '{7'd67,  7'd17,  7'd16 },
    '{7'd33,  7'd67,  7'd0  }, '{7'd50,  7'd33,  7'd17 },
    '{7'd17,  7'd83,  7'd0  }, '{7'd67,  7'd0,   7'd33 },
    '{7'd33,  7'd50,  7'd17 }, '{7'd0,   7'd100, 7'd0  },
    '{7'd50,  7'd17,  7'd33 }, '{7'd17,  7'd67,  7'd16 },
    '{7'd34,  7'd33,  7'd33 }, '{7'd0,   7'd83,  7'd17 },
    '{7'd50,  7'd0,   7'd50 }, '{7'd17,  7'd50,  7'd33 },
    '{7'd33,  7'd17,  7'd50 }, '{7'd0,   7'd67,  7'd33 },
    '{7'd17,  7'd33,  7'd50 }, '{7'd33,  7'd0,   7'd67 },
    '{7'd0,   7'd50,  7'd50 }, '{7'd17,  7'd17,  7'd66 },
    '{7'd0,   7'd33,  7'd67 }, '{7'd17,  7'd0,   7'd83 },
    '{7'd0,   7'd17,  7'd83 }, '{7'd0,   7'd0,   7'd100}
  };

  // Open-time percentage; entries outside the table read as zero
  function automatic pct_t pct_of(input logic [4:0] level, input logic [2:0] valve);
    pct_t pct;
    pct = '0;
    if ((level < 5'(ROM_LEVELS)) && (valve < 3'(ROM_VALVES))) begin
      pct = PERCENT_ROM[level][valve[1:0]];
    end
    return pct;
  endfunction

  // Percentage pre-scaled by the reciprocal of 100 (constant table)
  function automatic logic [30:0] pct_scaled(input logic [4:0] level,
                                             input logic [2:0] valve);
    logic [30:0] scaled;
    scaled = 31'(pct_of(level, valve)) * 31'(RECIP_100);
    return scaled;
  endfunction

endpackage

`default_nettype wire

// File: design/gas_valve_duty_sequencer_unit.sv
// A result is registered and valid in the cycle after its input transfer.
// One tick per clock unless a held result is stalled; the input is taken while
//   a result waits, as long as the result register is drained or not stalled.
// Reset (rst_n low at a clock edge): sequencer idle, all valves closed,
//   level 0, not halted, cycle_length 10000, auto_advance 1.
// ----------------------------------------------------------------------------
// Gas valve duty sequencer
// Time-proportional valve mixer: each cycle runs each valve's slot in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module gas_valve_duty_sequencer_unit #(
  parameter int NUM_VALVES = gvds_pkg::NUM_VALVES_DEF,
  parameter int NUM_LEVELS = gvds_pkg::NUM_LEVELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input tick channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [4:0]  in_requested_level,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_valve_open,
  output logic [1:0]       out_active_valve,
  output logic [4:0]       out_level_now,
  output logic             out_cycle_start,
  output logic             out_cycle_end,
  output logic             out_setting_error,
  output logic             out_halted,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  `include "gas_valve_duty_sequencer_unit_assert.svh"

  localparam int VW = (NUM_VALVES > 1) ? $clog2(NUM_VALVES) : 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0] cycle_length_r;
  logic        auto_advance_r;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_length_r <= gvds_pkg::CYCLE_RESET;
      auto_advance_r <= 1'b1;
    end else if (cfg_write) begin
      case (paddr[2])
        gvds_pkg::REG_CYCLE_LENGTH: cycle_length_r <= pwdata[15:0];
        gvds_pkg::REG_AUTO_ADVANCE: auto_advance_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      gvds_pkg::REG_CYCLE_LENGTH: prdata = {16'd0, cycle_length_r};
      gvds_pkg::REG_AUTO_ADVANCE: prdata = {31'd0, auto_advance_r};
      default:                    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake: the result register decouples the two channels. Take a new
  // tick unless a held result is being stalled.
  // --------------------------------------------------------------------------
  logic out_valid_r;
  logic accept;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  logic [VW-1:0] slot_valve_r,     slot_valve_nxt;
  logic [15:0]   slot_countdown_r, slot_countdown_nxt;
  logic          in_cycle_r,       in_cycle_nxt;
  logic [2:0]    open_mask_r,      open_mask_nxt;
  logic [4:0]    level_r,          level_nxt;
  logic          stopped_r,        stopped_nxt;

  // result payload
  logic [2:0] res_valve_open;
  logic [1:0] res_active_valve;
  logic [4:0] res_level_now;
  logic       res_cycle_start;
  logic       res_cycle_end;
  logic       res_setting_error;
  logic       res_halted;

  // datapath intermediates
  logic [4:0]        level_cur;
  logic [4:0]        req_clamped;
  logic [9:0]        pct_sum;
  logic              sum_ok;
  gvds_pkg::pct_t    pct;
  logic [30:0]       pct_k;
  logic [46:0]       timer_prod;
  logic [16:0]       timer_raw;
  logic [15:0]       timer;
  logic [15:0]       cd_loaded;
  logic [15:0]       cd_dec;
  logic [VW:0]       valve_inc;

  // Clamp out-of-range level requests to the top level
  assign req_clamped = ({1'b0, in_requested_level} >= 6'(NUM_LEVELS)) ?
                       5'(NUM_LEVELS - 1) : in_requested_level;

  // Latch the requested level at cycle start in manual mode
  assign level_cur = (!in_cycle_r && !auto_advance_r) ? req_clamped : level_r;

  // Percentages of the cycle's level must add up to a full cycle
  always_comb begin
    pct_sum = '0;
    for (int v = 0; v < NUM_VALVES; v++) begin
      pct_sum = pct_sum + 10'(gvds_pkg::pct_of(level_cur, 3'(v)));
    end
  end
  assign sum_ok = (pct_sum == gvds_pkg::FULL_PERCENT);

  // Slot time = pct * cycle_length / 100, via a pre-scaled reciprocal
  assign pct        = gvds_pkg::pct_of(level_cur, 3'(slot_valve_r));
  assign pct_k      = gvds_pkg::pct_scaled(level_cur, 3'(slot_valve_r));
  assign timer_prod = 47'(pct_k) * 47'(cycle_length_r);
  assign timer_raw  = timer_prod[46:gvds_pkg::RECIP_SHIFT];

  always_comb begin
    if (timer_raw == '0) begin
      timer = 16'd1;
    end else if (timer_raw[16]) begin
      timer = 16'hFFFF;
    end else begin
      timer = timer_raw[15:0];
    end
  end

  // Zero-percent slot burns one tick: add one, then the shared decrement
  always_comb begin
    if (pct != '0) begin
      cd_loaded = (slot_countdown_r == '0) ? timer : slot_countdown_r;
    end else begin
      cd_loaded = slot_countdown_r + 16'd1;
    end
  end
  assign cd_dec    = cd_loaded - 16'd1;
  assign valve_inc = {1'b0, slot_valve_r} + (VW+1)'(1);

  always_comb begin
    slot_valve_nxt     = slot_valve_r;
    slot_countdown_nxt = slot_countdown_r;
    in_cycle_nxt       = in_cycle_r;
    open_mask_nxt      = open_mask_r;
    level_nxt          = level_r;
    stopped_nxt        = stopped_r;

    res_valve_open    = '0;
    res_active_valve  = 2'(slot_valve_r);
    res_level_now     = level_r;
    res_cycle_start   = 1'b0;
    res_cycle_end     = 1'b0;
    res_setting_error = 1'b0;
    res_halted        = 1'b0;

    if (stopped_r) begin
      // Halted: hold everything, report closed valves
      res_halted = 1'b1;
    end else if (!in_cycle_r && !sum_ok) begin
      // Bad table row: close all valves and halt
      level_nxt         = level_cur;
      stopped_nxt       = 1'b1;
      open_mask_nxt     = '0;
      res_level_now     = level_cur;
      res_setting_error = 1'b1;
      res_halted        = 1'b1;
    end else begin
      level_nxt          = level_cur;
      in_cycle_nxt       = 1'b1;
      res_cycle_start    = !in_cycle_r;
      res_level_now      = level_cur;
      slot_countdown_nxt = cd_dec;

      // Open the slot's valve alone when its timer is loaded
      if ((pct != '0) && (slot_countdown_r == '0)) begin
        open_mask_nxt = 3'(8'(1) << slot_valve_r);
      end

      // Slot done: advance the valve, and close the cycle after the last
      if (cd_dec == '0) begin
        slot_valve_nxt = valve_inc[VW-1:0];
        if (valve_inc >= (VW+1)'(NUM_VALVES)) begin
          slot_valve_nxt = '0;
          in_cycle_nxt   = 1'b0;
          res_cycle_end  = 1'b1;
          if (auto_advance_r) begin
            level_nxt = (level_cur >= 5'(NUM_LEVELS - 1)) ? 5'd0 : level_cur + 5'd1;
          end
        end
      end
      res_valve_open = open_mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valve_r     <= '0;
      slot_countdown_r <= '0;
      in_cycle_r       <= 1'b0;
      open_mask_r      <= '0;
      level_r          <= '0;
      stopped_r        <= 1'b0;
    end else if (accept) begin
      slot_valve_r     <= slot_valve_nxt;
      slot_countdown_r <= slot_countdown_nxt;
      in_cycle_r       <= in_cycle_nxt;
      open_mask_r      <= open_mask_nxt;
      level_r          <= level_nxt;
      stopped_r        <= stopped_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register: load on each input transfer, hold while stalled
  // --------------------------------------------------------------------------
  logic       out_valid_nxt;
  logic [2:0] out_valve_open_r;
  logic [1:0] out_active_valve_r;
  logic [4:0] out_level_now_r;
  logic       out_cycle_start_r;
  logic       out_cycle_end_r;
  logic       out_setting_error_r;
  logic       out_halted_r;

  assign out_valid_nxt = accept | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_valve_open_r    <= res_valve_open;
      out_active_valve_r  <= res_active_valve;
      out_level_now_r     <= res_level_now;
      out_cycle_start_r   <= res_cycle_start;
      out_cycle_end_r     <= res_cycle_end;
      out_setting_error_r <= res_setting_error;
      out_halted_r        <= res_halted;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_valve_open    = out_valve_open_r;
  assign out_active_valve  = out_active_valve_r;
  assign out_level_now     = out_level_now_r;
  assign out_cycle_start   = out_cycle_start_r;
  assign out_cycle_end     = out_cycle_end_r;
  assign out_setting_error = out_setting_error_r;
  assign out_halted        = out_halted_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `GVDS_ASSERT_NEXT(a_halt_sticky, clk, rst_n, stopped_r, stopped_r, "halt state was left")
  `GVDS_ASSERT_IMPL(a_mask_single, clk, rst_n, 1'b1, $onehot0(open_mask_r),
                    "more than one valve open")
  `GVDS_ASSERT_IMPL(a_halt_closed, clk, rst_n, out_valid_r && out_halted_r,
                    out_valve_open_r == 3'd0, "valve open while halted")
  `GVDS_ASSERT_IMPL(a_err_no_cycle, clk, rst_n, out_valid_r && out_setting_error_r,
                    !out_cycle_start_r && !out_cycle_end_r && out_halted_r,
                    "setting error mixed with cycle flags")
  `GVDS_ASSERT_NEXT(a_stopped_closed, clk, rst_n, stopped_r, open_mask_r == 3'd0,
                    "valve mask not cleared after halt")

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gas valve duty sequencer testbench
// Drives ticks into the sequencer, tracks the valve slots with an
// independent behavioral model, and compares every result field by field.
// A directed table opens the run; randomized phases with several settings and
// one long slot follow. The register port is read back after reset and after
// every write.
// ----------------------------------------------------------------------------

module tb_top;

  // One result of the sequencer, as seen on the result channel
  typedef struct packed {
    logic [2:0] valve_open;
    logic [1:0] active_valve;
    logic [4:0] level_now;
    logic       cycle_start;
    logic       cycle_end;
    logic       setting_error;
    logic       halted;
  } tick_result_t;

  // Directed row: a tick, and where obvious, the result it must give
  typedef struct packed {
    logic [4:0] req;
    logic       typed;
    logic [2:0] mask;
    logic [1:0] valve;
    logic [4:0] level;
    logic       start;
    logic       stop;
  } dir_row_t;

  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_TOGGLE, SINK_HEAVY} sink_mode_t;

  localparam int DIR_ROWS = 21;
  localparam int PHASES   = 8;
  localparam int PHASE_TICKS = 50;
  localparam int PRESSURE_AFTER = 100;
  localparam int PRESSURE_HOLD  = 300;
  localparam int SETTLE_CYCLES  = 3;
  localparam int LONG_LEVEL     = 25;
  localparam int LONG_CYCLE     = 600;

  // With cycle_length 1 and auto_advance 0 every slot lasts one tick, so the
  // first rows read straight off the percentage table.
  localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    '{5'd0,  1'b1, 3'd1, 2'd0, 5'd0,  1'b1, 1'b0},  // level 0, full valve one
    '{5'd31, 1'b1, 3'd1, 2'd1, 5'd0,  1'b0, 1'b0},  // zero-percent slot keeps mask
    '{5'd31, 1'b1, 3'd1, 2'd2, 5'd0,  1'b0, 1'b1},
    '{5'd31, 1'b1, 3'd1, 2'd0, 5'd27, 1'b1, 1'b0},  // out-of-range level clamps
    '{5'd0,  1'b1, 3'd1, 2'd1, 5'd27, 1'b0, 1'b0},  // mid-cycle request ignored
    '{5'd0,  1'b1, 3'd4, 2'd2, 5'd27, 1'b0, 1'b1},
    '{5'd28, 1'b1, 3'd4, 2'd0, 5'd27, 1'b1, 1'b0},
    '{5'd21, 1'b1, 3'd4, 2'd1, 5'd27, 1'b0, 1'b0},
    '{5'd10, 1'b1, 3'd4, 2'd2, 5'd27, 1'b0, 1'b1},
    '{5'd13, 1'b1, 3'd1, 2'd0, 5'd13, 1'b1, 1'b0},  // zero timer runs one tick
    '{5'd0,  1'b1, 3'd2, 2'd1, 5'd13, 1'b0, 1'b0},
    '{5'd0,  1'b1, 3'd4, 2'd2, 5'd13, 1'b0, 1'b1},
    '{5'd11, 1'b1, 3'd4, 2'd0, 5'd11, 1'b1, 1'b0},
    '{5'd31, 1'b1, 3'd2, 2'd1, 5'd11, 1'b0, 1'b0},
    '{5'd31, 1'b1, 3'd2, 2'd2, 5'd11, 1'b0, 1'b1},
    '{5'd14, 1'b0, 3'd0, 2'd0, 5'd0,  1'b0, 1'b0},
    '{5'd3,  1'b0, 3'd0, 2'd0, 5'd0,  1'b0, 1'b0},
    '{5'd3,  1'b0, 3'd0, 2'd0, 5'd0,  1'b0, 1'b0},
    '{5'd26, 1'b0, 3'd0, 2'd0, 5'd0,  1'b0, 1'b0},
    '{5'd1,  1'b0, 3'd0, 2'd0, 5'd0,  1'b0, 1'b0},
    '{5'd1,  1'b0, 3'd0, 2'd0, 5'd0,  1'b0, 1'b0}
  };

  // Per-phase settings; a cycle length of zero here means pick one at random
  localparam int unsigned PHASE_CYCLES [PHASES] = '{2, 1, 100, 7, 99, 0, 101, 0};
  localparam bit          PHASE_AUTO   [PHASES] = '{1, 0, 1, 1, 0, 1, 0, 1};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid;
  logic        in_stall;
  logic [4:0]  in_requested_level;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_valve_open;
  logic [1:0]  out_active_valve;
  logic [4:0]  out_level_now;
  logic        out_cycle_start;
  logic        out_cycle_end;
  logic        out_setting_error;
  logic        out_halted;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  gas_valve_duty_sequencer_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_requested_level (in_requested_level),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_valve_open     (out_valve_open),
    .out_active_valve   (out_active_valve),
    .out_level_now      (out_level_now),
    .out_cycle_start    (out_cycle_start),
    .out_cycle_end      (out_cycle_end),
    .out_setting_error  (out_setting_error),
    .out_halted         (out_halted),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Mixer model: register copies and slot state, all at their reset values
  // --------------------------------------------------------------------------
  logic [15:0] cfg_cycle_len = gvds_pkg::CYCLE_RESET;
  logic        cfg_auto      = 1'b1;
  int unsigned mix_slot      = 0;
  logic [15:0] mix_count     = '0;
  logic        mix_busy      = 1'b0;
  logic [2:0]  mix_mask      = '0;
  logic [4:0]  mix_level     = '0;
  logic        mix_halted    = 1'b0;

  tick_result_t valve_ticks_due [$];
  int           mismatches   = 0;
  int           results_seen = 0;
  int           burst_left   = 0;

  // Table share of one valve at one level; anything off the table is zero
  function automatic int unsigned valve_share(input int unsigned lvl, input int unsigned vlv);
    if (lvl >= gvds_pkg::ROM_LEVELS || vlv >= gvds_pkg::ROM_VALVES) begin
      return 0;
    end
    return gvds_pkg::PERCENT_ROM[lvl][vlv];
  endfunction

  // Advance the model by one tick and return the result it must produce
  task automatic advance_mixer(input logic [4:0] req, output tick_result_t res);
    int unsigned total;
    int unsigned pct;
    int unsigned span;
    int unsigned cur_valve;
    res = '0;
    if (mix_halted) begin
      // frozen: valves shut, last slot and level reported
      res.active_valve = 2'(mix_slot);
      res.level_now    = mix_level;
      res.halted       = 1'b1;
      return;
    end
    if (!mix_busy) begin
      // cycle start: latch the level unless it steps on its own
      if (!cfg_auto) begin
        mix_level = (req >= gvds_pkg::NUM_LEVELS_DEF) ?
                    5'(gvds_pkg::NUM_LEVELS_DEF - 1) : req;
      end
      total = 0;
      for (int v = 0; v < gvds_pkg::NUM_VALVES_DEF; v++) begin
        total += valve_share(mix_level, v);
      end
      if (total != gvds_pkg::FULL_PERCENT) begin
        mix_halted = 1'b1;
        mix_mask   = '0;
        res.active_valve  = 2'(mix_slot);
        res.level_now     = mix_level;
        res.setting_error = 1'b1;
        res.halted        = 1'b1;
        return;
      end
      mix_busy        = 1'b1;
      res.cycle_start = 1'b1;
    end
    cur_valve        = mix_slot;
    res.active_valve = 2'(mix_slot);
    res.level_now    = mix_level;
    pct = valve_share(mix_level, cur_valve);
    if (pct != 0) begin
      if (mix_count == 0) begin
        // open this valve alone for its share of the cycle
        span = pct * cfg_cycle_len / gvds_pkg::FULL_PERCENT;
        if (span == 0) begin
          span = 1;
        end
        if (span > 65535) begin
          span = 65535;
        end
        mix_count = 16'(span);
        mix_mask  = 3'(1 << cur_valve);
      end
    end else begin
      mix_count = mix_count + 16'd1;
    end
    mix_count = mix_count - 16'd1;
    if (mix_count == 0) begin
      mix_slot++;
      if (mix_slot >= gvds_pkg::NUM_VALVES_DEF) begin
        res.cycle_end = 1'b1;
        mix_slot      = 0;
        mix_busy      = 1'b0;
        if (cfg_auto) begin
          mix_level = (mix_level >= gvds_pkg::NUM_LEVELS_DEF - 1) ?
                      5'd0 : mix_level + 5'd1;
        end
      end
    end
    res.valve_open = mix_mask;
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Compare every accepted result with the oldest outstanding tick
  always @(posedge clk) begin
    tick_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (valve_ticks_due.size() == 0) begin
        $display("%0t: result transfer expected none, got valve_open %0d level %0d",
                 $time, out_valve_open, out_level_now);
        mismatches++;
      end else begin
        want = valve_ticks_due.pop_front();
        check_field("valve_open", 16'(want.valve_open), 16'(out_valve_open));
        check_field("active_valve", 16'(want.active_valve), 16'(out_active_valve));
        check_field("level_now", 16'(want.level_now), 16'(out_level_now));
        check_field("cycle_start", 16'(want.cycle_start), 16'(out_cycle_start));
        check_field("cycle_end", 16'(want.cycle_end), 16'(out_cycle_end));
        check_field("setting_error", 16'(want.setting_error), 16'(out_setting_error));
        check_field("halted", 16'(want.halted), 16'(out_halted));
      end
      results_seen++;
    end
  end

  // --------------------------------------------------------------------------
  // Register port: setup cycle, then access cycle until pready
  // --------------------------------------------------------------------------
  task automatic apb_xfer(input bit wr, input logic idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    // return to idle so the next transfer starts clean
    @(negedge clk);
  endtask

  task automatic check_reg(input logic idx);
    logic [31:0] rd;
    apb_xfer(1'b0, idx, 32'd0, rd);
    if (idx == gvds_pkg::REG_CYCLE_LENGTH) begin
      check_field("cycle_length readback", cfg_cycle_len, rd[15:0]);
    end else begin
      check_field("auto_advance readback", 16'(cfg_auto), 16'(rd[0]));
    end
  endtask

  task automatic set_reg(input logic idx, input logic [31:0] value);
    logic [31:0] unused;
    apb_xfer(1'b1, idx, value, unused);
    if (idx == gvds_pkg::REG_CYCLE_LENGTH) begin
      cfg_cycle_len = value[15:0];
    end else begin
      cfg_auto = value[0];
    end
    check_reg(idx);
  endtask

  // --------------------------------------------------------------------------
  // Tick source: bursts of random length, random gaps between them.
  // Entered and left at a falling edge; valid stays high across a burst.
  // --------------------------------------------------------------------------
  task automatic send_tick(input logic [4:0] req, input bit typed, input tick_result_t typed_want);
    tick_result_t predicted;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid           <= 1'b1;
    in_requested_level <= req;
    // hold the payload until the transfer happens
    do @(posedge clk); while (in_stall);
    advance_mixer(req, predicted);
    valve_ticks_due.push_back(typed ? typed_want : predicted);
    @(negedge clk);
  endtask

  // Drop valid, wait for every outstanding result, then let the block settle
  task automatic drain_ticks();
    in_valid <= 1'b0;
    while (valve_ticks_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result sink: stalls on a changing pattern; once, a long hold-off fills
  // the block while the source keeps offering ticks.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int         hold_left;
    int         mode_left;
    int         beat;
    bit         pressure_done;
    sink_mode_t mode;
    out_stall     = 1'b0;
    hold_left     = 0;
    mode_left     = 0;
    beat          = 0;
    pressure_done = 1'b0;
    mode          = SINK_OPEN;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!pressure_done && results_seen >= PRESSURE_AFTER) begin
        pressure_done = 1'b1;
        hold_left     = PRESSURE_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        beat++;
        case (mode)
          SINK_OPEN: begin
            out_stall <= 1'b0;
          end
          SINK_RANDOM: begin
            out_stall <= ($urandom_range(0, 2) == 0);
          end
          SINK_TOGGLE: begin
            out_stall <= beat[0];
          end
          default: begin
            out_stall <= (beat % 4 != 0);
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    dir_row_t     row;
    tick_result_t want;
    int unsigned  cl;
    in_valid           = 1'b0;
    in_requested_level = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values of both registers
    check_reg(gvds_pkg::REG_CYCLE_LENGTH);
    check_reg(gvds_pkg::REG_AUTO_ADVANCE);

    // directed table: one-tick slots, level latched from the input
    set_reg(gvds_pkg::REG_CYCLE_LENGTH, 32'd1);
    set_reg(gvds_pkg::REG_AUTO_ADVANCE, 32'd0);
    for (int i = 0; i < DIR_ROWS; i++) begin
      row  = DIRECTED_ROWS[i];
      want = '0;
      want.valve_open   = row.mask;
      want.active_valve = row.valve;
      want.level_now    = row.level;
      want.cycle_start  = row.start;
      want.cycle_end    = row.stop;
      send_tick(row.req, row.typed, want);
    end
    drain_ticks();

    // random phases over several settings; state carries across phases
    for (int p = 0; p < PHASES; p++) begin
      cl = (PHASE_CYCLES[p] == 0) ? $urandom_range(3, 40) : PHASE_CYCLES[p];
      set_reg(gvds_pkg::REG_CYCLE_LENGTH, cl);
      set_reg(gvds_pkg::REG_AUTO_ADVANCE, 32'(PHASE_AUTO[p]));
      repeat (PHASE_TICKS) send_tick(5'($urandom_range(0, 31)), 1'b0, '0);
      drain_ticks();
    end

    // finish the running cycle quickly, then one long slot
    set_reg(gvds_pkg::REG_CYCLE_LENGTH, 32'd1);
    set_reg(gvds_pkg::REG_AUTO_ADVANCE, 32'd0);
    while (mix_busy) send_tick(5'($urandom_range(0, 31)), 1'b0, '0);
    drain_ticks();
    set_reg(gvds_pkg::REG_CYCLE_LENGTH, 32'(LONG_CYCLE));
    do send_tick(5'(LONG_LEVEL), 1'b0, '0); while (mix_slot == 0);
    drain_ticks();
    // shorten the remaining slots and close the cycle
    set_reg(gvds_pkg::REG_CYCLE_LENGTH, 32'd1);
    while (mix_busy) send_tick(5'($urandom_range(0, 31)), 1'b0, '0);
    drain_ticks();

    if (mismatches == 0) begin
      $display("gas_valve_duty_sequencer_unit: match");
    end else begin
      $display("gas_valve_duty_sequencer_unit: mismatch");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin : watchdog
    #20_000_000;
    $display("gas_valve_duty_sequencer_unit: mismatch");
    $finish;
  end

endmodule
